FILE: src/jsf_pkg.sv
// jsf_pkg: shared constants, types and the fire color ramp for the Julia set pixel colorer.
// No dependencies; used by every other file except jsf_if through scoped names.
`timescale 1ns / 1ps
package jsf_pkg;

    localparam int TEX_W      = 320;
    localparam int TEX_H      = 240;
    localparam int ITER_LIMIT = 16;

    // Front end scaling: 12288 / 320 = 192 / 5 and 12288 / 240 = 256 / 5.
    localparam int X_SCALE_NUM = 192;
    localparam int Y_SCALE_NUM = 256;
    // floor(n / 5) = (n * 52429) >> 18 for n below 2^17
    localparam int RECIP_5     = 52429;
    localparam int RECIP_SH    = 18;

    // Divider numerator width: largest |q| << 12 stays below 2^27
    localparam int DIV_W       = 27;
    localparam int CNT_W       = $clog2(DIV_W + 1);

    localparam int N_W         = $clog2(ITER_LIMIT + 1);
    localparam logic signed [31:0] ESCAPE_LIMIT = 32'sd16384;
    localparam int BLACK_FROM  = 31;

    // configuration register indexes
    localparam logic [1:0] REG_C_REAL = 2'd0;
    localparam logic [1:0] REG_C_IMAG = 2'd1;
    localparam logic [1:0] REG_ZOOM   = 2'd2;

    typedef struct packed {
        logic signed [31:0] z_re;
        logic signed [31:0] z_im;
    } t_zpair;

    function automatic logic [15:0] fire_color(input logic [5:0] k);
        logic [9:0] v;
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
        v = {1'b0, k, 3'b000};
        r = 10'd255;
        g = 10'd255;
        b = 10'd255;
        if (v < 10'd64) begin
            r = {v[7:0], 2'b00};
            g = 10'd0;
            b = 10'd0;
        end else if (v < 10'd128) begin
            g = {v[7:0] - 8'd64, 2'b00};
            b = 10'd0;
        end else if (v < 10'd192) begin
            b = {v[7:0] - 8'd128, 2'b00};
        end
        if (k >= 6'(BLACK_FROM)) begin
            fire_color = 16'h0000;
        end else begin
            fire_color = {r[7:3], g[7:2], b[7:3]};
        end
    endfunction

endpackage

FILE: src/jsf_if.sv
// jsf_if: valid/ready channel interfaces for pixel requests, colored results and register writes.
// Depends on nothing.
`timescale 1ns / 1ps
interface jsf_pix_if;
    logic       valid;
    logic       ready;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface jsf_rgb_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_rgb565;
    logic [4:0]  iteration_count;
    modport source (output valid, pixel_rgb565, iteration_count, input ready);
    modport sink   (input valid, pixel_rgb565, iteration_count, output ready);
endinterface

interface jsf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/jsf_front.sv
// jsf_front: maps a pixel coordinate to its Q12 starting point with a bit-serial zoom divide.
// Depends on jsf_pkg and jsf_pix_if.
`timescale 1ns / 1ps
module jsf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsf_pix_if.sink          i_pix,
    input  logic [15:0]      i_zoom,
    output logic             o_valid,
    output jsf_pkg::t_zpair  o_z,
    input  logic             i_ready
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_RECIP = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0]  r_state;
    logic [jsf_pkg::CNT_W-1:0] r_cnt;
    logic [8:0]  r_mag_x;
    logic [7:0]  r_mag_y;
    logic        r_neg_x;
    logic        r_neg_y;
    logic [16:0] r_prod_x;
    logic [16:0] r_prod_y;
    logic [15:0] r_zoom;
    logic [jsf_pkg::DIV_W-1:0] r_num_x;
    logic [jsf_pkg::DIV_W-1:0] r_num_y;
    logic [15:0] r_rem_x;
    logic [15:0] r_rem_y;

    logic signed [10:0] w_dx;
    logic signed [8:0]  w_dy;
    logic [32:0] w_rx;
    logic [32:0] w_ry;
    logic [16:0] w_tx;
    logic [16:0] w_ty;
    logic [31:0] w_qx;
    logic [31:0] w_qy;

    assign w_dx = signed'({2'b00, i_pix.pixel_x}) - 11'(jsf_pkg::TEX_W / 2);
    assign w_dy = signed'({1'b0, i_pix.pixel_y}) - 9'(jsf_pkg::TEX_H / 2);
    assign w_rx = {16'd0, r_prod_x} * 33'(jsf_pkg::RECIP_5);
    assign w_ry = {16'd0, r_prod_y} * 33'(jsf_pkg::RECIP_5);
    // one restoring step per axis: shift in a numerator bit, try the subtract
    assign w_tx = {r_rem_x, r_num_x[jsf_pkg::DIV_W-1]};
    assign w_ty = {r_rem_y, r_num_y[jsf_pkg::DIV_W-1]};
    assign w_qx = 32'(r_num_x);
    assign w_qy = 32'(r_num_y);

    assign i_pix.ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_PUSH);
    assign o_z.z_re    = r_neg_x ? -signed'(w_qx) : signed'(w_qx);
    assign o_z.z_im    = r_neg_y ? -signed'(w_qy) : signed'(w_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_pix.valid) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_RECIP;
                S_RECIP: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == jsf_pkg::CNT_W'(jsf_pkg::DIV_W - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_neg_x <= w_dx[10];
                r_neg_y <= w_dy[8];
                r_mag_x <= w_dx[10] ? 9'(-w_dx) : w_dx[8:0];
                r_mag_y <= w_dy[8]  ? 8'(-w_dy) : w_dy[7:0];
                r_zoom  <= (i_zoom == 16'd0) ? 16'd1 : i_zoom;
            end
            S_SCALE: begin
                r_prod_x <= {8'd0, r_mag_x} * 17'(jsf_pkg::X_SCALE_NUM);
                r_prod_y <= {9'd0, r_mag_y} * 17'(jsf_pkg::Y_SCALE_NUM);
            end
            S_RECIP: begin
                r_num_x <= {w_rx[jsf_pkg::RECIP_SH +: jsf_pkg::DIV_W-12], 12'd0};
                r_num_y <= {w_ry[jsf_pkg::RECIP_SH +: jsf_pkg::DIV_W-12], 12'd0};
                r_rem_x <= '0;
                r_rem_y <= '0;
            end
            S_DIV: begin
                if (w_tx >= {1'b0, r_zoom}) begin
                    r_rem_x <= 16'(w_tx - {1'b0, r_zoom});
                    r_num_x <= {r_num_x[jsf_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    r_rem_x <= w_tx[15:0];
                    r_num_x <= {r_num_x[jsf_pkg::DIV_W-2:0], 1'b0};
                end
                if (w_ty >= {1'b0, r_zoom}) begin
                    r_rem_y <= 16'(w_ty - {1'b0, r_zoom});
                    r_num_y <= {r_num_y[jsf_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    r_rem_y <= w_ty[15:0];
                    r_num_y <= {r_num_y[jsf_pkg::DIV_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= jsf_pkg::CNT_W'(jsf_pkg::DIV_W)) else $error("divide counter overrun");
    a_push_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DIV) else $error("push without divide");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUSH |-> r_rem_x < r_zoom && r_rem_y < r_zoom)
        else $error("remainder not below divisor");
endmodule

FILE: src/jsf_fifo.sv
// jsf_fifo: two-entry queue of starting points between the front and back ends.
// Depends on jsf_pkg.
`timescale 1ns / 1ps
module jsf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jsf_pkg::t_zpair i_z,
    output logic            o_ready,
    output logic            o_valid,
    output jsf_pkg::t_zpair o_z,
    input  logic            i_ready
);
    jsf_pkg::t_zpair r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_z     = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_z;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overrun");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("pointer mismatch");
    a_ptr_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_wp != r_rp) else $error("pointer mismatch");
endmodule

FILE: src/jsf_back.sv
// jsf_back: runs z = z*z + c on one starting point, colors the count, holds the result.
// Depends on jsf_pkg and jsf_rgb_if.
`timescale 1ns / 1ps
module jsf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  jsf_pkg::t_zpair     i_z,
    output logic                o_ready,
    input  logic signed [13:0]  i_c_real,
    input  logic signed [13:0]  i_c_imag,
    jsf_rgb_if.source           o_rgb
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]  r_state;
    logic [jsf_pkg::N_W-1:0] r_n;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic signed [31:0] r_pr;
    logic signed [31:0] r_pi;
    logic signed [31:0] r_px;
    logic        r_ovalid;
    logic [15:0] r_rgb;
    logic [4:0]  r_cnt_out;

    logic signed [31:0] w_re2;
    logic signed [31:0] w_im2;
    logic signed [31:0] w_sum;
    logic        w_esc;
    logic [jsf_pkg::N_W-1:0] w_n1;
    logic        w_free;

    assign w_re2  = r_pr >>> 12;
    assign w_im2  = r_pi >>> 12;
    assign w_sum  = w_re2 + w_im2;
    assign w_esc  = w_sum > jsf_pkg::ESCAPE_LIMIT;
    assign w_n1   = r_n + 1'b1;
    assign w_free = !r_ovalid || o_rgb.ready;

    assign o_ready               = (r_state == S_IDLE);
    assign o_rgb.valid           = r_ovalid;
    assign o_rgb.pixel_rgb565    = r_rgb;
    assign o_rgb.iteration_count = r_cnt_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_HOLD && w_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rgb.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_MUL;
                S_MUL:  r_state <= S_CHK;
                S_CHK: begin
                    if (w_esc || w_n1 == jsf_pkg::N_W'(jsf_pkg::ITER_LIMIT)) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_HOLD: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_zr <= i_z.z_re;
                r_zi <= i_z.z_im;
                r_n  <= '0;
            end
            S_MUL: begin
                r_pr <= r_zr * r_zr;
                r_pi <= r_zi * r_zi;
                r_px <= r_zr * r_zi;
            end
            S_CHK: begin
                if (!w_esc) begin
                    r_zr <= w_re2 - w_im2 + 32'(i_c_real);
                    r_zi <= (r_px >>> 11) + 32'(i_c_imag);
                    r_n  <= w_n1;
                end
            end
            S_HOLD: begin
                if (w_free) begin
                    r_rgb     <= jsf_pkg::fire_color({r_n, 1'b0});
                    r_cnt_out <= r_n;
                end
            end
            default: ;
        endcase
    end

    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_n <= jsf_pkg::N_W'(jsf_pkg::ITER_LIMIT))
        else $error("iteration count overrun");
    a_chk_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHK |-> $past(r_state) == S_MUL) else $error("check without products");
    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_HOLD) else $error("result from wrong state");
endmodule

FILE: src/julia_set_pixel_fire_color_top.sv
// julia_set_pixel_fire_color_top: Julia set pixel colorer, Q12 fixed point, fire ramp.
// Depends on jsf_pkg, jsf_if, jsf_front, jsf_fifo and jsf_back.
// Path of a request: the front (map, scale, 27-step zoom divide, queue write), then the
// escape checks in the back (1 to 16 checks) and the color register, which holds the
// result until it is taken.
// Concurrency: front and back overlap through a 2-entry queue; the front takes a new
// request once it has pushed the last one, while the back may still iterate.
// Reset (i_rst_n low, synchronous) empties every stage and loads c = 0.75, zoom = 3000.
`timescale 1ns / 1ps
module julia_set_pixel_fire_color_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsf_pix_if.sink   i_pix,
    jsf_cfg_if.sink   i_cfg,
    jsf_rgb_if.source o_rgb
);
    // configuration registers
    logic signed [13:0] r_c_real;
    logic signed [13:0] r_c_imag;
    logic [15:0]        r_zoom;

    // front end to queue
    logic            w_f_valid;
    logic            w_f_ready;
    jsf_pkg::t_zpair w_f_z;
    // queue to back end
    logic            w_b_valid;
    logic            w_b_ready;
    jsf_pkg::t_zpair w_b_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real <= 14'sd3072;
            r_c_imag <= 14'sd0;
            r_zoom   <= 16'd3000;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                jsf_pkg::REG_C_REAL: r_c_real <= i_cfg.data[13:0];
                jsf_pkg::REG_C_IMAG: r_c_imag <= i_cfg.data[13:0];
                jsf_pkg::REG_ZOOM:   r_zoom   <= i_cfg.data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // front: coordinate mapping and zoom divide
    jsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_zoom  (r_zoom),
        .o_valid (w_f_valid),
        .o_z     (w_f_z),
        .i_ready (w_f_ready)
    );

    jsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_z     (w_f_z),
        .o_ready (w_f_ready),
        .o_valid (w_b_valid),
        .o_z     (w_b_z),
        .i_ready (w_b_ready)
    );

    // back: escape-time iteration, color lookup, output register
    jsf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_b_valid),
        .i_z      (w_b_z),
        .o_ready  (w_b_ready),
        .i_c_real (r_c_real),
        .i_c_imag (r_c_imag),
        .o_rgb    (o_rgb)
    );
endmodule

FILE: dv/julia_set_pixel_fire_color_top_test.sv
// Self-checking bench for the Julia set pixel colorer: drives pixel requests and
// register writes, predicts each color and iteration count, checks the result stream.
// Depends on jsf_pkg, jsf_if and the julia_set_pixel_fire_color_top RTL.
`timescale 1ns / 1ps
module julia_set_pixel_fire_color_top_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [15:0] rgb;
        logic [4:0]  count;
    } t_color;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    jsf_pix_if pix ();
    jsf_rgb_if rgb ();
    jsf_cfg_if cfg ();

    julia_set_pixel_fire_color_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .i_cfg   (cfg.sink),
        .o_rgb   (rgb.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the register file
    logic signed [31:0] julia_c_re = 32'sd3072;
    logic signed [31:0] julia_c_im = 32'sd0;
    logic [15:0]        view_zoom  = 16'd3000;

    t_color pending_colors[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     hold_off = 1'b0;   // long receiver stall request
    int     burst_left = 0;

    // Map one axis onto the Q12 plane; all divides truncate toward zero
    function automatic logic signed [31:0] map_axis(input int p, input int size);
        logic signed [31:0] t;
        logic signed [31:0] zm;
        zm = (view_zoom == 16'd0) ? 32'sd1 : $signed({16'd0, view_zoom});
        t = (p - size / 2) * 12288;
        t = t / size;
        t = t * 4096;
        return t / zm;
    endfunction

    function automatic t_color predict_color(input logic [8:0] px, input logic [7:0] py);
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [31:0] re2;
        logic signed [31:0] im2;
        logic signed [31:0] nr;
        logic [31:0]        k;
        logic [31:0]        v;
        logic [31:0]        r;
        logic [31:0]        g;
        logic [31:0]        b;
        int                 n;
        t_color             res;
        zr = map_axis(int'(px), jsf_pkg::TEX_W);
        zi = map_axis(int'(py), jsf_pkg::TEX_H);
        for (n = 0; n < jsf_pkg::ITER_LIMIT; n++) begin
            re2 = (zr * zr) >>> 12;
            im2 = (zi * zi) >>> 12;
            if (re2 + im2 > jsf_pkg::ESCAPE_LIMIT) break;
            nr = re2 - im2 + julia_c_re;
            zi = ((zr * zi) >>> 11) + julia_c_im;
            zr = nr;
        end
        k = 32'(n) * 2;
        v = k * 8;
        if (v < 64) begin
            r = 4 * v; g = 0; b = 0;
        end else if (v < 128) begin
            r = 255; g = 4 * (v - 64); b = 0;
        end else if (v < 192) begin
            r = 255; g = 255; b = 4 * (v - 128);
        end else begin
            r = 255; g = 255; b = 255;
        end
        res.rgb = (k >= jsf_pkg::BLACK_FROM) ? 16'h0000
                : {r[7:3], g[7:2], b[7:3]};
        res.count = 5'(n);
        return res;
    endfunction

    // Receiver: stalls on its own pseudo-random pattern, or holds off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgb.ready <= 1'b0;
        end else begin
            rgb.ready <= !hold_off && ($urandom_range(0, 9) < 7);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_color got;
        t_color want;
        if (i_rst_n && rgb.valid && rgb.ready) begin
            got.rgb = rgb.pixel_rgb565;
            got.count = rgb.iteration_count;
            if (pending_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rgb=%h count=%0d", got.rgb, got.count);
            end else begin
                want = pending_colors.pop_front();
                if (got.rgb !== want.rgb || got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rgb=%h count=%0d, got rgb=%h count=%0d",
                                 want.rgb, want.count, got.rgb, got.count);
                end
            end
        end
    end

    // Watchdog: cycles with no accepted handshake on any channel
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready)
            || (cfg.valid && cfg.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one pixel request; bursts with random gaps between them.
    // Valid stays up between requests of a burst; gaps and drains drop it.
    task automatic send_pixel(input logic [8:0] px, input logic [7:0] py, input bit gaps);
        if (gaps && burst_left == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        pix.valid <= 1'b1;
        pix.pixel_x <= px;
        pix.pixel_y <= py;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        pending_colors.push_back(predict_color(px, py));
        if (burst_left > 0) burst_left--;
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        case (idx)
            jsf_pkg::REG_C_REAL: julia_c_re = 32'(signed'(value[13:0]));
            jsf_pkg::REG_C_IMAG: julia_c_im = 32'(signed'(value[13:0]));
            jsf_pkg::REG_ZOOM:   view_zoom = value;
            default: ;
        endcase
    endtask

    task automatic set_view(input logic [13:0] cre, input logic [13:0] cim,
                            input logic [15:0] zm);
        wait_drained();
        write_reg(jsf_pkg::REG_C_REAL, {2'b00, cre});
        write_reg(jsf_pkg::REG_C_IMAG, {2'b00, cim});
        write_reg(jsf_pkg::REG_ZOOM, zm);
        cfg.valid <= 1'b0;
    endtask

    // Corners, center, out-of-texture coordinates and all-ones fields
    task automatic test_directed();
        send_pixel(9'd0, 8'd0, 0);
        send_pixel(9'd319, 8'd239, 0);
        send_pixel(9'd160, 8'd120, 0);
        send_pixel(9'd0, 8'd239, 0);
        send_pixel(9'd319, 8'd0, 0);
        send_pixel(9'd511, 8'd255, 0);
        send_pixel(9'd320, 8'd240, 0);
        send_pixel(9'd170, 8'd120, 0);
        // interior of the set: c = 0, the largest zoom value gives points that never escape
        set_view(14'd0, 14'd0, 16'd65535);
        send_pixel(9'd160, 8'd120, 0);
        send_pixel(9'd200, 8'd100, 0);
        send_pixel(9'd511, 8'd255, 0);
        // zoom of zero acts as one; overflow wraps
        set_view(14'h2000, 14'h1FFF, 16'd0);
        send_pixel(9'd0, 8'd0, 0);
        send_pixel(9'd161, 8'd121, 0);
        set_view(14'h1FFF, 14'h2000, 16'd1);
        send_pixel(9'd161, 8'd119, 0);
        send_pixel(9'd160, 8'd120, 0);
    endtask

    // Random pixels, mostly inside the texture, under several register settings
    task automatic test_random();
        int phase;
        int i;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_view(14'd3072, 14'd0, 16'd3000);
                1: set_view(14'(-3200), 14'd2600, 16'd4096);
                2: set_view(14'($urandom), 14'($urandom), 16'($urandom));
                3: set_view(14'(-1600), 14'(-700), 16'd2000);
                4: set_view(14'($urandom_range(0, 16383)), 14'd500,
                            16'($urandom_range(1000, 8000)));
                default: set_view(14'd1150, 14'(-1000), 16'd6000);
            endcase
            for (i = 0; i < 70; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(9'($urandom), 8'($urandom), 1);
                else
                    send_pixel(9'($urandom_range(0, 319)), 8'($urandom_range(0, 239)), 1);
            end
        end
    endtask

    // Receiver holds off while requests pile up, then sender pauses for a full drain
    task automatic test_backpressure();
        int i;
        wait_drained();
        set_view(14'd3072, 14'd0, 16'd3000);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (i = 0; i < 12; i++)
                    send_pixel(9'($urandom_range(0, 319)), 8'($urandom_range(0, 239)), 0);
                pix.valid <= 1'b0;
                @(posedge i_clk);
            end
        join
        wait_drained();
        for (i = 0; i < 10; i++)
            send_pixel(9'($urandom_range(0, 319)), 8'($urandom_range(0, 239)), 0);
    endtask

    initial begin
        pix.valid = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rgb.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
src/jsf_pkg.sv
src/jsf_if.sv
src/jsf_front.sv
src/jsf_fifo.sv
src/jsf_back.sv
src/julia_set_pixel_fire_color_top.sv
dv/julia_set_pixel_fire_color_top_test.sv
